// ===== sv/sths_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sths_pkg: shared types and constants of the sorted timestamp history store
// reading and result payloads, cell control word, sizing constants
// ----------------------------------------------------------------------------
package sths_pkg;

  // number of history entries (one cell each)
  localparam int CAPACITY = 256;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam longint unsigned MIN_MS  = 64'd60000;
  localparam longint unsigned HOUR_MS = 60 * MIN_MS;
  localparam longint unsigned TOL_MS  = 5 * MIN_MS;
  // width of range_hours times HOUR_MS
  localparam int SPAN_W = 27;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_UPDATE = 2'd1,
    OP_INSERT = 2'd2,
    OP_EVICT  = 2'd3
  } sths_op_e;

  typedef struct packed {
    logic     en;
    sths_op_e op;
  } sths_ctl_t;

  typedef struct packed {
    logic               reading_valid;
    logic [63:0]        timestamp_ms;
    logic signed [15:0] glucose_value;
    logic               last_in_batch;
    logic [63:0]        now_ms;
    logic [4:0]         range_hours;
  } sths_in_t;

  typedef struct packed {
    logic        changed;
    logic        batch_changed;
    logic [8:0]  entry_count;
    logic [31:0] generation;
    logic        covered;
  } sths_out_t;

endpackage

// ===== sv/sths_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sths_cell: one history entry of the sorted chain
// compares its timestamp against the reading, then keeps, updates or shifts
// ----------------------------------------------------------------------------
module sths_cell (
  input  logic                 clk_i,
  input  logic                 cmp_en_i,
  input  sths_pkg::sths_ctl_t  ctl_i,
  input  logic                 occ_i,
  input  logic [63:0]          ts_i,
  input  logic signed [15:0]   val_i,
  input  logic [63:0]          left_time_i,
  input  logic signed [15:0]   left_val_i,
  input  logic                 left_lt_i,
  input  logic [63:0]          right_time_i,
  input  logic signed [15:0]   right_val_i,
  input  logic                 right_lt_i,
  output logic [63:0]          time_o,
  output logic signed [15:0]   val_o,
  output logic                 lt_o,
  output logic                 eq_o,
  output logic                 diff_o,
  output logic [63:0]          time_nxt_o
);

  logic [63:0]        time_q, time_d;
  logic signed [15:0] val_q, val_d;
  logic               lt_q, eq_q, diff_q;

  // compare phase
  always_ff @(posedge clk_i) begin
    if (cmp_en_i) begin
      lt_q   <= occ_i && (time_q < ts_i);
      eq_q   <= occ_i && (time_q == ts_i);
      diff_q <= occ_i && (time_q == ts_i) && (val_q != val_i);
    end
  end

  // apply phase
  always_comb begin
    time_d = time_q;
    val_d  = val_q;
    case (ctl_i.op)
      sths_pkg::OP_UPDATE: begin
        if (eq_q) begin
          val_d = val_i;
        end
      end
      sths_pkg::OP_INSERT: begin
        // older entries stay, the slot at the insert point takes the reading
        if (!lt_q) begin
          if (!left_lt_i) begin
            time_d = left_time_i;
            val_d  = left_val_i;
          end else begin
            time_d = ts_i;
            val_d  = val_i;
          end
        end
      end
      sths_pkg::OP_EVICT: begin
        // older part moves down one slot, oldest falls off
        if (lt_q) begin
          if (right_lt_i) begin
            time_d = right_time_i;
            val_d  = right_val_i;
          end else begin
            time_d = ts_i;
            val_d  = val_i;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      time_q <= time_d;
      val_q  <= val_d;
    end
  end

  assign time_o     = time_q;
  assign val_o      = val_q;
  assign lt_o       = lt_q;
  assign eq_o       = eq_q;
  assign diff_o     = diff_q;
  assign time_nxt_o = time_d;

endmodule

// ===== sv/sorted_timestamp_history_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timestamp_history_store: sorted reading history with eviction
// chain of entry cells kept in timestamp order, oldest in cell zero
// ----------------------------------------------------------------------------
// Keeps up to CAPACITY (256) readings sorted by timestamp, oldest first, in a
// chain of cells. Each input transaction is one reading and yields exactly one
// result transaction. In the compare phase every cell checks its timestamp
// against the reading in parallel, and in the apply phase all cells update at
// once, either rewriting the matching value, shifting the newer part up by one
// to open a slot, or (when full) shifting the older part down to evict the
// oldest entry; a full store drops a reading older than all entries. A new
// reading is taken in the same cycle that the previous result is written to
// the output register, so readings follow without an idle state unless the
// result side stalls. The output register lets one finished result wait while
// the next reading is compared. No clearing pass is needed after reset:
// occupancy follows from the entry count.
// ----------------------------------------------------------------------------
module sorted_timestamp_history_store (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sths_pkg::sths_in_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sths_pkg::sths_out_t  out_data_o
);

  localparam int N       = sths_pkg::CAPACITY;
  localparam int W       = sths_pkg::CNT_W;
  localparam int SPAN_LW = sths_pkg::SPAN_W;

  // sequencer codes
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CMP   = 2'd1;
  localparam logic [1:0] ST_APPLY = 2'd2;

  logic [1:0]          state_q, state_d;
  sths_pkg::sths_in_t  req_q;
  logic [63:0]         bound_q;
  logic [W-1:0]        count_q, count_d;
  logic [31:0]         gen_q, gen_d;
  logic                batch_q, batch_d;
  logic                out_valid_q;
  sths_pkg::sths_out_t out_data_q;

  // per-cell wires
  logic [63:0]        cell_time [N];
  logic signed [15:0] cell_val  [N];
  logic [63:0]        cell_nxt  [N];
  logic [N-1:0]       cell_lt, cell_eq, cell_diff, cell_occ;

  logic                in_fire, cmp_en, apply_go, active, full, changed;
  logic [SPAN_LW-1:0]  span;
  sths_pkg::sths_ctl_t ctl;

  // apply can finish when the output register is free or being drained
  assign apply_go   = (state_q == ST_APPLY) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((state_q == ST_IDLE) || apply_go);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign cmp_en     = (state_q == ST_CMP);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_CMP;
      ST_CMP:   state_d = ST_APPLY;
      ST_APPLY: begin
        if (apply_go) begin
          state_d = in_fire ? ST_CMP : ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // reading payload held through both phases, coverage bound set in the compare phase
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= in_data_i;
    end
  end

  // window start plus tolerance, wrapping mod 2^64
  assign span = SPAN_LW'(req_q.range_hours) * SPAN_LW'(sths_pkg::HOUR_MS);

  always_ff @(posedge clk_i) begin
    if (cmp_en) begin
      bound_q <= req_q.now_ms - 64'(span) + sths_pkg::TOL_MS;
    end
  end

  // cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [63:0]        l_time, r_time;
    logic signed [15:0] l_val, r_val;
    logic               l_lt, r_lt;

    assign cell_occ[i] = (count_q > W'(i));

    if (i == 0) begin : g_first
      // nothing older than cell zero
      assign l_time = '0;
      assign l_val  = '0;
      assign l_lt   = 1'b1;
    end else begin : g_mid_l
      assign l_time = cell_time[i-1];
      assign l_val  = cell_val[i-1];
      assign l_lt   = cell_lt[i-1];
    end

    if (i == N - 1) begin : g_last
      assign r_time = '0;
      assign r_val  = '0;
      assign r_lt   = 1'b0;
    end else begin : g_mid_r
      assign r_time = cell_time[i+1];
      assign r_val  = cell_val[i+1];
      assign r_lt   = cell_lt[i+1];
    end

    sths_cell u_cell (
      .clk_i        (clk_i),
      .cmp_en_i     (cmp_en),
      .ctl_i        (ctl),
      .occ_i        (cell_occ[i]),
      .ts_i         (req_q.timestamp_ms),
      .val_i        (req_q.glucose_value),
      .left_time_i  (l_time),
      .left_val_i   (l_val),
      .left_lt_i    (l_lt),
      .right_time_i (r_time),
      .right_val_i  (r_val),
      .right_lt_i   (r_lt),
      .time_o       (cell_time[i]),
      .val_o        (cell_val[i]),
      .lt_o         (cell_lt[i]),
      .eq_o         (cell_eq[i]),
      .diff_o       (cell_diff[i]),
      .time_nxt_o   (cell_nxt[i])
    );
  end

  // apply decision from the registered compare flags
  assign active = req_q.reading_valid && (req_q.timestamp_ms != 64'd0);
  assign full   = (count_q == W'(N));

  always_comb begin
    ctl.en  = apply_go;
    ctl.op  = sths_pkg::OP_HOLD;
    changed = 1'b0;
    count_d = count_q;
    if (active) begin
      if (|cell_eq) begin
        // same timestamp: rewrite value
        ctl.op  = sths_pkg::OP_UPDATE;
        changed = |cell_diff;
      end else if (full) begin
        // full: evict the oldest, but drop a reading older than everything stored
        if (cell_lt[0]) begin
          ctl.op  = sths_pkg::OP_EVICT;
          changed = 1'b1;
        end
      end else begin
        ctl.op  = sths_pkg::OP_INSERT;
        changed = 1'b1;
        count_d = count_q + W'(1);
      end
    end
  end

  // batch bookkeeping
  always_comb begin
    batch_d = batch_q || changed;
    gen_d   = gen_q;
    if (req_q.last_in_batch) begin
      gen_d = gen_q + 32'(batch_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      gen_q       <= '0;
      batch_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (apply_go) begin
        count_q     <= count_d;
        gen_q       <= gen_d;
        batch_q     <= batch_d && !req_q.last_in_batch;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register; coverage uses cell zero after this reading
  always_ff @(posedge clk_i) begin
    if (apply_go) begin
      out_data_q.changed       <= changed;
      out_data_q.batch_changed <= batch_d;
      out_data_q.entry_count   <= 9'(count_d);
      out_data_q.generation    <= gen_d;
      out_data_q.covered       <= (count_d != '0) && (req_q.now_ms != 64'd0) &&
                                  (cell_nxt[0] <= bound_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== sv/sths_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sths_checker: port-level checks of the sorted timestamp history store
// bound to the top level
// ----------------------------------------------------------------------------
module sths_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input sths_pkg::sths_out_t out_data_o
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // an accepted reading needs its compare cycle before the next one
  a_cmp_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("reading accepted during compare");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.entry_count <= sths_pkg::CAPACITY)
    else $error("entry count above capacity");

  a_batch_or: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.changed |-> out_data_o.batch_changed)
    else $error("change missing from batch flag");

  a_cover_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.covered |-> out_data_o.entry_count != 9'd0)
    else $error("coverage reported on empty history");

endmodule

bind sorted_timestamp_history_store sths_checker u_sths_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ===== dv/sorted_timestamp_history_store_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timestamp_history_store_test: self-checking bench for the history store
// a table of hand-picked readings, then random reading batches through a mirror
// ----------------------------------------------------------------------------
// Readings go in through the valid/stall input channel and results come back
// one per reading on the output channel. A behavioral mirror of the sorted
// history (update, ordered insert, oldest eviction, batch generation, window
// coverage) predicts each result when its reading transaction is accepted.
// The opening table carries hand-written results for the easy rows. The
// random part is mostly new readings with rising timestamps that fill the
// store and drive it into eviction, mixed with rewrites, in-between and
// too-old readings, and ignored ones. Both channels idle at random in phases.
// ----------------------------------------------------------------------------
module sorted_timestamp_history_store_test;

  // random readings to send after the table
  localparam int RANDOM_READINGS = 1630;
  localparam int TOTAL_READINGS  = RANDOM_READINGS + 20;
  localparam longint unsigned T0 = 64'd1_000_000;

  typedef struct {
    sths_pkg::sths_in_t  rd;
    bit                  typed;
    sths_pkg::sths_out_t want;
  } stim_row_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  sths_pkg::sths_in_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sths_pkg::sths_out_t out_data;

  // mirror of the store
  longint unsigned hist_time [sths_pkg::CAPACITY];
  logic [15:0]     hist_value[sths_pkg::CAPACITY];
  int              hist_count  = 0;
  logic [31:0]     gen_count   = '0;
  bit              batch_dirty = 1'b0;

  stim_row_t           dir_rows[$];
  sths_pkg::sths_out_t pending_results[$];
  bit                  cur_typed   = 1'b0;
  sths_pkg::sths_out_t cur_expect  = '0;
  int                  row_idx     = 0;
  int                  random_sent = 0;
  int                  issued      = 0;
  longint unsigned     next_stamp  = 64'd1_700_000_000_000;
  bit                  stim_done   = 1'b0;
  int                  mismatch_count = 0;

  sorted_timestamp_history_store i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // mirror: applies one reading and returns the result the block should give
  // ---------------------------------------------------------------------------
  function automatic sths_pkg::sths_out_t apply_reading(sths_pkg::sths_in_t rd);
    int                  pos;
    int                  i;
    bit                  changed;
    longint unsigned     window_start;
    sths_pkg::sths_out_t res;
    changed = 1'b0;
    pos     = 0;
    if (rd.reading_valid && rd.timestamp_ms != 64'd0) begin
      while (pos < hist_count && hist_time[pos] < rd.timestamp_ms) pos++;
      if (pos < hist_count && hist_time[pos] == rd.timestamp_ms) begin
        // same timestamp: only a different value counts as a change
        changed = (hist_value[pos] != rd.glucose_value);
        hist_value[pos] = rd.glucose_value;
      end else if (hist_count == sths_pkg::CAPACITY) begin
        // full: a reading older than everything is dropped, otherwise the
        // oldest entry leaves and the lower part slides down one slot
        if (pos != 0) begin
          for (i = 0; i < pos - 1; i++) begin
            hist_time[i]  = hist_time[i + 1];
            hist_value[i] = hist_value[i + 1];
          end
          hist_time[pos - 1]  = rd.timestamp_ms;
          hist_value[pos - 1] = rd.glucose_value;
          changed = 1'b1;
        end
      end else begin
        for (i = hist_count; i > pos; i--) begin
          hist_time[i]  = hist_time[i - 1];
          hist_value[i] = hist_value[i - 1];
        end
        hist_time[pos]  = rd.timestamp_ms;
        hist_value[pos] = rd.glucose_value;
        hist_count++;
        changed = 1'b1;
      end
    end
    batch_dirty       = batch_dirty | changed;
    res.changed       = changed;
    res.batch_changed = batch_dirty;
    if (rd.last_in_batch) begin
      if (batch_dirty) gen_count = gen_count + 32'd1;
      batch_dirty = 1'b0;
    end
    res.entry_count = 9'(hist_count);
    res.generation  = gen_count;
    // window start and its tolerance bound both wrap at 64 bits
    res.covered = 1'b0;
    if (hist_count != 0 && rd.now_ms != 64'd0) begin
      window_start = rd.now_ms - 64'(rd.range_hours) * sths_pkg::HOUR_MS;
      res.covered  = (hist_time[0] <= window_start + sths_pkg::TOL_MS);
    end
    return res;
  endfunction

  function automatic sths_pkg::sths_in_t reading(bit vld, longint unsigned ts,
                                                 logic [15:0] val, bit last,
                                                 longint unsigned now, logic [4:0] hrs);
    sths_pkg::sths_in_t rd;
    rd.reading_valid = vld;
    rd.timestamp_ms  = ts;
    rd.glucose_value = val;
    rd.last_in_batch = last;
    rd.now_ms        = now;
    rd.range_hours   = hrs;
    return rd;
  endfunction

  function automatic sths_pkg::sths_out_t outcome(bit chg, bit bchg, int cnt, int gen,
                                                  bit cov);
    sths_pkg::sths_out_t res;
    res.changed       = chg;
    res.batch_changed = bchg;
    res.entry_count   = 9'(cnt);
    res.generation    = 32'(gen);
    res.covered       = cov;
    return res;
  endfunction

  function automatic void add_row(sths_pkg::sths_in_t rd, bit typed,
                                  sths_pkg::sths_out_t want);
    stim_row_t row;
    row.rd    = rd;
    row.typed = typed;
    row.want  = want;
    dir_rows.push_back(row);
  endfunction

  // ---------------------------------------------------------------------------
  // random reading, shaped by what the mirror holds right now
  // ---------------------------------------------------------------------------
  function automatic sths_pkg::sths_in_t next_random_reading();
    sths_pkg::sths_in_t rd;
    int unsigned        pick;
    int unsigned        idx;
    longint unsigned    oldest;
    pick = $urandom_range(0, 99);
    rd.reading_valid = 1'b1;
    rd.last_in_batch = ($urandom_range(0, 3) == 0);
    rd.glucose_value = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(40, 400));
    rd.range_hours   = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                                    : 5'($urandom_range(1, 24));
    if (pick < 52 || hist_count == 0) begin
      // normal flow: a newer timestamp than any earlier normal-flow reading
      next_stamp += $urandom_range(1, 300000);
      rd.timestamp_ms = next_stamp;
    end else if (pick < 66) begin
      // rewrite of a stored entry, same or new value
      idx = $urandom_range(0, hist_count - 1);
      rd.timestamp_ms = hist_time[idx];
      if ($urandom_range(0, 1) != 0) rd.glucose_value = hist_value[idx];
    end else if (pick < 76) begin
      // lands just above a stored entry
      idx = $urandom_range(0, hist_count - 1);
      rd.timestamp_ms = hist_time[idx] + $urandom_range(1, 100000);
    end else if (pick < 86) begin
      // older than the oldest entry: dropped once the store is full
      rd.timestamp_ms = hist_time[0] - $urandom_range(1, 50000);
    end else if (pick < 92) begin
      rd.reading_valid = 1'b0;
      rd.timestamp_ms  = {$urandom, $urandom};
    end else if (pick < 96) begin
      rd.timestamp_ms = 64'd0;
    end else begin
      rd.timestamp_ms = {$urandom, $urandom};
    end
    // now_ms mostly near the point where coverage flips for the oldest entry
    oldest = (hist_count != 0) ? hist_time[0] : next_stamp;
    pick   = $urandom_range(0, 99);
    if (pick < 70) begin
      rd.now_ms = oldest + 64'(rd.range_hours) * sths_pkg::HOUR_MS - sths_pkg::TOL_MS
                  - 64'd600000 + $urandom_range(0, 1200000);
    end else if (pick < 85) begin
      rd.now_ms = next_stamp;
    end else if (pick < 95) begin
      rd.now_ms = {$urandom, $urandom};
    end else begin
      rd.now_ms = 64'd0;
    end
    return rd;
  endfunction

  // idle share in percent: sender light / receiver heavy, then swapped, then none
  function automatic int idle_share(bit sender);
    int phase;
    phase = (issued * 3) / TOTAL_READINGS;
    if (phase == 0) return sender ? 26 : 67;
    if (phase == 1) return sender ? 67 : 26;
    return 0;
  endfunction

  function automatic void report_mismatch(string field, longint unsigned want,
                                          longint unsigned got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s: expected %0h, got %0h (t=%0t)", field, want, got, $time);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // directed table: extremes, update/insert/ignore cases, coverage edges
  // rows with a typed result check against it, the rest against the mirror
  // ---------------------------------------------------------------------------
  initial begin
    // empty store after reset, invalid reading closing an empty batch
    add_row(reading(0, 0, 16'h0000, 1, 0, 1), 1, outcome(0, 0, 0, 0, 0));
    // valid flag but zero timestamp is ignored
    add_row(reading(1, 0, 16'h1234, 0, 5000, 1), 1, outcome(0, 0, 0, 0, 0));
    // first insert, most negative value, now of zero never covers
    add_row(reading(1, T0, 16'h8000, 0, 0, 24), 1, outcome(1, 1, 1, 0, 0));
    // same value again: no change, but the batch still closes dirty
    add_row(reading(1, T0, 16'h8000, 1, 0, 1), 1, outcome(0, 1, 1, 1, 0));
    // value change, window bound lands exactly on the oldest entry
    add_row(reading(1, T0, 16'h7FFF, 1, T0 + sths_pkg::HOUR_MS - sths_pkg::TOL_MS, 1), 1,
            outcome(1, 1, 1, 2, 1));
    // one millisecond short of coverage, clean batch keeps the generation
    add_row(reading(1, T0, 16'h7FFF, 1,
                    T0 + sths_pkg::HOUR_MS - sths_pkg::TOL_MS - 1, 1), 1,
            outcome(0, 0, 1, 2, 0));
    // invalid reading, largest now
    add_row(reading(0, T0 + 5, 16'hFFFF, 0, 64'hFFFF_FFFF_FFFF_FFFF, 24), 1,
            outcome(0, 0, 1, 2, 1));
    // largest timestamp goes to the top
    add_row(reading(1, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0000, 0, 0, 1), 1,
            outcome(1, 1, 2, 2, 0));
    // older than everything while not full: inserted at the bottom
    add_row(reading(1, 500, 16'hFFFF, 1, 0, 1), 1, outcome(1, 1, 3, 3, 0));
    // zero-length window
    add_row(reading(0, 0, 16'h0000, 0, 500, 0), 1, outcome(0, 0, 3, 3, 1));
    // tolerance bound wraps to zero
    add_row(reading(1, 0, 16'h0000, 1, 64'd0 - sths_pkg::TOL_MS, 0), 1,
            outcome(0, 0, 3, 3, 0));
    // window start wraps below zero, middle insert
    add_row(reading(1, 2_000_000, 16'h0064, 0, 1, 31), 1, outcome(1, 1, 4, 3, 1));
    // rewrite of the oldest, longest regular window on its boundary
    add_row(reading(1, 500, 16'h0000, 1,
                    500 + 24 * sths_pkg::HOUR_MS - sths_pkg::TOL_MS, 24), 1,
            outcome(1, 1, 4, 4, 1));
    add_row(reading(1, 1, 16'h5555, 0,
                    500 + 24 * sths_pkg::HOUR_MS - sths_pkg::TOL_MS - 1, 12), 0, '0);
    add_row(reading(1, 64'h8000_0000_0000_0000, 16'hAAAA, 1,
                    64'h8000_0000_0000_0000, 16), 0, '0);
    add_row(reading(1, 64'h5555_5555_5555_5555, 16'h0001, 0,
                    64'hAAAA_AAAA_AAAA_AAAA, 5'b10101), 0, '0);
    add_row(reading(1, 64'hAAAA_AAAA_AAAA_AAAA, 16'hFFFE, 1,
                    64'h5555_5555_5555_5555, 5'b01010), 0, '0);
    add_row(reading(1, 64'hFFFF_FFFF_FFFF_FFFE, 16'h7FFF, 0, 3 * sths_pkg::HOUR_MS, 3),
            0, '0);
    add_row(reading(1, 64'hFFFF_FFFF_FFFF_FFFE, 16'h7FFF, 1, 3 * sths_pkg::HOUR_MS + 1, 3),
            0, '0);
    add_row(reading(0, 64'hFFFF_FFFF_FFFF_FFFF, 16'h8001, 1, 7, 1), 0, '0);
  end

  // ---------------------------------------------------------------------------
  // input side: log the accepted transaction, then present the next reading
  // ---------------------------------------------------------------------------
  always @(posedge clk or negedge rst_n) begin : feed_readings
    sths_pkg::sths_out_t predicted;
    sths_pkg::sths_in_t  nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        // the mirror advances even when the row has a typed result
        predicted = apply_reading(in_data);
        pending_results.push_back(cur_typed ? cur_expect : predicted);
      end
      // a held reading stays put until taken
      if (!in_valid || !in_stall) begin
        if ($urandom_range(0, 99) < idle_share(1'b1)) begin
          in_valid <= 1'b0;
        end else if (row_idx < dir_rows.size()) begin
          in_valid   <= 1'b1;
          in_data    <= dir_rows[row_idx].rd;
          cur_typed  <= dir_rows[row_idx].typed;
          cur_expect <= dir_rows[row_idx].want;
          row_idx++;
          issued++;
        end else if (random_sent < RANDOM_READINGS) begin
          nxt = next_random_reading();
          random_sent++;
          in_valid  <= 1'b1;
          in_data   <= nxt;
          cur_typed <= 1'b0;
          issued++;
        end else begin
          in_valid  <= 1'b0;
          stim_done <= 1'b1;
        end
      end
    end
  end

  // output side: random back-pressure
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < idle_share(1'b0));
    end
  end

  // result check against the oldest outstanding expectation
  always @(posedge clk) begin : check_results
    sths_pkg::sths_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 0, out_data);
      end else begin
        want = pending_results.pop_front();
        if (out_data.changed != want.changed)
          report_mismatch("changed", want.changed, out_data.changed);
        if (out_data.batch_changed != want.batch_changed)
          report_mismatch("batch_changed", want.batch_changed, out_data.batch_changed);
        if (out_data.entry_count != want.entry_count)
          report_mismatch("entry_count", want.entry_count, out_data.entry_count);
        if (out_data.generation != want.generation)
          report_mismatch("generation", want.generation, out_data.generation);
        if (out_data.covered != want.covered)
          report_mismatch("covered", want.covered, out_data.covered);
      end
    end
  end

  // reset, wait for the stream to drain, let stray results show up, verdict
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
